// ----- rtl/ttf_pkg.sv -----
// Shared types and constants for the tagged task queue.
// Depends on nothing; used by ttf_slot and tagged_task_fifo_core.
package ttf_pkg;

    localparam int TAG_W = 16;
    localparam int REF_W = 32;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_POP    = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    localparam logic [TAG_W-1:0] TAG_FIRST = 16'd1;
    localparam logic [TAG_W-1:0] TAG_LAST  = 16'd65534;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [REF_W-1:0] callback_ref;
        logic [REF_W-1:0] context_ref;
        logic [TAG_W-1:0] task_tag;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [TAG_W-1:0] result_tag;
        logic [REF_W-1:0] out_callback;
        logic [REF_W-1:0] out_context;
    } out_item_t;

    typedef struct packed {
        logic             valid;
        logic [TAG_W-1:0] tag;
        logic [REF_W-1:0] callback_ref;
        logic [REF_W-1:0] context_ref;
    } entry_t;

    typedef struct packed {
        logic             add;
        logic             remove;
        logic             pop;
        logic [TAG_W-1:0] new_tag;
        logic [TAG_W-1:0] key;
        logic [REF_W-1:0] callback_ref;
        logic [REF_W-1:0] context_ref;
    } slot_ctrl_t;

endpackage

// ----- rtl/ttf_slot.sv -----
// One queue slot of the compacting chain: holds an entry, compares its tag and
// takes its right neighbor's entry when the queue closes up. Depends on ttf_pkg.
module ttf_slot
(
    input  logic                clk,
    input  logic                rst_n,
    input  ttf_pkg::slot_ctrl_t ctrl,
    input  logic                prev_valid,
    input  logic                hit_in,
    input  ttf_pkg::entry_t     right,
    output ttf_pkg::entry_t     entry,
    output logic                hit_out
);

    logic                          valid_reg;
    logic                          valid_next;
    logic [ttf_pkg::TAG_W-1:0]     tag_reg;
    logic [ttf_pkg::TAG_W-1:0]     tag_next;
    logic [ttf_pkg::REF_W-1:0]     cb_reg;
    logic [ttf_pkg::REF_W-1:0]     cb_next;
    logic [ttf_pkg::REF_W-1:0]     ctx_reg;
    logic [ttf_pkg::REF_W-1:0]     ctx_next;
    logic                          match;
    logic                          shift;
    logic                          load;

    assign match   = valid_reg && (tag_reg == ctrl.key);
    assign hit_out = hit_in | match;
    assign shift   = ctrl.pop | (ctrl.remove & hit_out);
    assign load    = ctrl.add & ~valid_reg & prev_valid;

    assign entry.valid        = valid_reg;
    assign entry.tag          = tag_reg;
    assign entry.callback_ref = cb_reg;
    assign entry.context_ref  = ctx_reg;

    always_comb
    begin
        valid_next = valid_reg;
        tag_next   = tag_reg;
        cb_next    = cb_reg;
        ctx_next   = ctx_reg;
        if (shift)
        begin
            valid_next = right.valid;
            tag_next   = right.tag;
            cb_next    = right.callback_ref;
            ctx_next   = right.context_ref;
        end
        else if (load)
        begin
            valid_next = 1'b1;
            tag_next   = ctrl.new_tag;
            cb_next    = ctrl.callback_ref;
            ctx_next   = ctrl.context_ref;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
        cb_reg  <= cb_next;
        ctx_reg <= ctx_next;
    end

endmodule

// ----- rtl/tagged_task_fifo_core.sv -----
// Top level of the tagged task queue: a chain of ttf_slot stages plus tag counter
// and result register. Depends on ttf_pkg and ttf_slot.
//
// The block takes one command in every clock cycle; busy never rises. Each command
// gives exactly one result beat, marked by done in the cycle right after the
// command was taken, and the receiver has to take it then. Adds, removes and pops
// all update the chain with the result register; each slot compares its tag at
// once, and a pop, or a remove from the matching slot on, moves entries one place
// toward the head. The queue holds QUEUE_DEPTH entries, oldest always in slot 0.
module tagged_task_fifo_core
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ttf_pkg::in_item_t item,
    output logic              done,
    output ttf_pkg::out_item_t result
);

    ttf_pkg::entry_t              chain [QUEUE_DEPTH+1];
    logic [QUEUE_DEPTH:0]         hit;
    ttf_pkg::slot_ctrl_t          ctrl;
    logic [ttf_pkg::TAG_W-1:0]    next_tag_reg;
    logic [ttf_pkg::TAG_W-1:0]    next_tag_next;
    ttf_pkg::out_item_t           result_reg;
    ttf_pkg::out_item_t           result_next;
    logic                         done_reg;
    logic                         full;

    assign busy = 1'b0;
    assign full = chain[QUEUE_DEPTH-1].valid;

    assign ctrl.add          = start && (item.cmd == ttf_pkg::CMD_ADD);
    assign ctrl.remove       = start && (item.cmd == ttf_pkg::CMD_REMOVE);
    assign ctrl.pop          = start && (item.cmd == ttf_pkg::CMD_POP);
    assign ctrl.new_tag      = next_tag_reg;
    assign ctrl.key          = item.task_tag;
    assign ctrl.callback_ref = item.callback_ref;
    assign ctrl.context_ref  = item.context_ref;

    assign chain[QUEUE_DEPTH] = '0;
    assign hit[0]             = 1'b0;

    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin : g_slot
            logic prev_valid;
            if (i == 0)
            begin : g_head
                assign prev_valid = 1'b1;
            end
            else
            begin : g_body
                assign prev_valid = chain[i-1].valid;
            end

            ttf_slot u_slot
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .prev_valid (prev_valid),
                .hit_in     (hit[i]),
                .right      (chain[i+1]),
                .entry      (chain[i]),
                .hit_out    (hit[i+1])
            );
        end
    endgenerate

    always_comb
    begin
        result_next   = '0;
        next_tag_next = next_tag_reg;
        case (item.cmd)
            ttf_pkg::CMD_ADD:
            begin
                if (full)
                begin
                    result_next.status = ttf_pkg::ST_FULL;
                end
                else
                begin
                    result_next.status     = ttf_pkg::ST_OK;
                    result_next.result_tag = next_tag_reg;
                    if (start)
                    begin
                        if (next_tag_reg == ttf_pkg::TAG_LAST)
                        begin
                            next_tag_next = ttf_pkg::TAG_FIRST;
                        end
                        else
                        begin
                            next_tag_next = next_tag_reg + 1'b1;
                        end
                    end
                end
            end
            ttf_pkg::CMD_REMOVE:
            begin
                result_next.status = hit[QUEUE_DEPTH] ? ttf_pkg::ST_OK
                                                      : ttf_pkg::ST_NOT_FOUND;
            end
            ttf_pkg::CMD_POP:
            begin
                if (chain[0].valid)
                begin
                    result_next.status       = ttf_pkg::ST_OK;
                    result_next.result_tag   = chain[0].tag;
                    result_next.out_callback = chain[0].callback_ref;
                    result_next.out_context  = chain[0].context_ref;
                end
                else
                begin
                    result_next.status = ttf_pkg::ST_EMPTY;
                end
            end
            default:
            begin
                result_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_tag_reg <= ttf_pkg::TAG_FIRST;
            done_reg     <= 1'b0;
        end
        else
        begin
            next_tag_reg <= next_tag_next;
            done_reg     <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
